// ===== rtl/mhpq_pkg.sv =====
// Shared constants and types for the binary max-heap priority queue.
// No dependencies; imported by max_heap_priority_queue and its testbench.
package mhpq_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = 11;
    localparam int KEY_W    = 32;

    // Stream payload widths.
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_USER_W = 3;

    localparam logic FUNC_INSERT  = 1'b0;
    localparam logic FUNC_EXTRACT = 1'b1;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } err_t;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_UP      = 6'b000010,
        S_EX_READ = 6'b000100,
        S_DOWN    = 6'b001000,
        S_PLACE   = 6'b010000,
        S_RESULT  = 6'b100000
    } state_t;

endpackage

// ===== rtl/max_heap_priority_queue.sv =====
// Binary max-heap priority queue with the heap held in one on-chip memory.
// An insert sifts up in S_UP (up to 10 levels); an extract reads the root and the last entry in
// S_EX_READ and sinks that entry in S_DOWN (up to 9 levels). Each key is written where it lands,
// and S_RESULT registers the result beat; rejects go straight there. One item at a time: the
// next beat is taken only once the result is registered, and S_RESULT holds on output stall.
// Reset: rst_n clears the entry count and the handshake state; heap contents stay undefined.
//
// Depends on mhpq_pkg for sizes, the state encoding and the error codes.
module max_heap_priority_queue
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [mhpq_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // value[31:0]
    input  logic [mhpq_pkg::IN_USER_W-1:0]  s_axis_tuser,  // func[0]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [mhpq_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // out_value[31:0], count[42:32], zero
    output logic [mhpq_pkg::OUT_USER_W-1:0] m_axis_tuser   // out_valid[0], error_code[2:1]
);
    import mhpq_pkg::*;

    localparam int CW = ADDR_W + 2;  // child index width, holds 2*pos+2

    // The heap itself: one write port and two synchronous read ports. Reads and the
    // write of a level always touch different entries, since a sift moves strictly
    // toward the root or strictly toward the leaves.
    logic [KEY_W-1:0] heap_mem [CAPACITY];

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_wa;
    logic [KEY_W-1:0]   mem_wd;
    logic [ADDR_W-1:0]  ra0;
    logic [ADDR_W-1:0]  ra1;
    logic signed [KEY_W-1:0] rd0_reg;
    logic signed [KEY_W-1:0] rd1_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            heap_mem[mem_wa] <= mem_wd;
        end
        rd0_reg <= heap_mem[ra0];
        rd1_reg <= heap_mem[ra1];
    end

    // Control state.
    state_t               state_reg, state_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [ADDR_W-1:0]    pos_reg, pos_next;
    // The key being sifted is held here and written only where it finally lands;
    // entries it passes are shifted one level instead of swapped.
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [KEY_W-1:0]     top_reg, top_next;
    err_t                 err_reg, err_next;
    logic                 hit_reg, hit_next;

    // Output register.
    logic                 m_valid_reg, m_valid_next;
    logic [KEY_W-1:0]     o_value_reg, o_value_next;
    logic                 o_hit_reg, o_hit_next;
    err_t                 o_err_reg, o_err_next;
    logic [COUNT_W-1:0]   o_count_reg, o_count_next;

    // Index arithmetic for sift-up: parent and grandparent of the current slot.
    logic [ADDR_W-1:0] up_parent;
    logic [ADDR_W-1:0] up_grand;
    assign up_parent = (pos_reg - 1'b1) >> 1;
    assign up_grand  = (up_parent - 1'b1) >> 1;

    // Index arithmetic for sift-down. On equal children the right one wins.
    logic [CW-1:0]        dn_left, dn_right, nx_left, nx_right, cnt_ext;
    logic                 right_ok, pick_right;
    logic [ADDR_W-1:0]    pick_idx;
    logic signed [KEY_W-1:0] pick_val;

    assign cnt_ext    = CW'(count_reg);
    assign dn_left    = CW'({pos_reg, 1'b1});
    assign dn_right   = dn_left + 1'b1;
    assign right_ok   = dn_right < cnt_ext;
    assign pick_right = right_ok && !(rd0_reg > rd1_reg);
    assign pick_idx   = pick_right ? dn_right[ADDR_W-1:0] : dn_left[ADDR_W-1:0];
    assign pick_val   = pick_right ? rd1_reg : rd0_reg;
    assign nx_left    = CW'({pick_idx, 1'b1});
    assign nx_right   = nx_left + 1'b1;

    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        key_next     = key_reg;
        top_next     = top_reg;
        err_next     = err_reg;
        hit_next     = hit_reg;
        mem_we       = 1'b0;
        mem_wa       = pos_reg;
        mem_wd       = key_reg;
        ra0          = '0;
        ra1          = '0;
        m_valid_next = m_valid_reg && !m_axis_tready;
        o_value_next = o_value_reg;
        o_hit_next   = o_hit_reg;
        o_err_next   = o_err_reg;
        o_count_next = o_count_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                // Reads are launched speculatively: the parent of the new slot for an
                // insert, the root and the last entry for an extract.
                if (s_axis_tuser[0] == FUNC_EXTRACT)
                begin
                    ra0 = '0;
                    ra1 = ADDR_W'(count_reg - 1'b1);
                end
                else
                begin
                    ra0 = ADDR_W'((count_reg - 1'b1) >> 1);
                end
                if (s_axis_tvalid)
                begin
                    err_next = ERR_NONE;
                    hit_next = 1'b0;
                    pos_next = '0;
                    key_next = $signed(s_axis_tdata[KEY_W-1:0]);
                    if (s_axis_tuser[0] == FUNC_EXTRACT)
                    begin
                        if (count_reg == '0)
                        begin
                            err_next   = ERR_EMPTY;
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            count_next = count_reg - 1'b1;
                            hit_next   = 1'b1;
                            state_next = S_EX_READ;
                        end
                    end
                    else
                    begin
                        if (count_reg == COUNT_W'(CAPACITY))
                        begin
                            err_next   = ERR_FULL;
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                            pos_next   = ADDR_W'(count_reg);
                            // An empty heap takes the key straight into the root.
                            state_next = (count_reg == '0) ? S_PLACE : S_UP;
                        end
                    end
                end
            end

            S_UP:
            begin
                // rd0 holds the parent of pos.
                if (key_reg > rd0_reg)
                begin
                    mem_we   = 1'b1;
                    mem_wa   = pos_reg;
                    mem_wd   = rd0_reg;
                    pos_next = up_parent;
                    ra0      = up_grand;
                    if (up_parent == '0)
                    begin
                        state_next = S_PLACE;
                    end
                end
                else
                begin
                    mem_we     = 1'b1;
                    state_next = S_RESULT;
                end
            end

            S_EX_READ:
            begin
                // rd0 is the maximum, rd1 the last entry, now to be sifted from the root.
                top_next = rd0_reg;
                key_next = rd1_reg;
                ra0      = ADDR_W'(1);
                ra1      = ADDR_W'(2);
                if (count_reg == '0)
                begin
                    state_next = S_RESULT;
                end
                else if (count_reg == COUNT_W'(1))
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    state_next = S_DOWN;
                end
            end

            S_DOWN:
            begin
                // rd0 and rd1 hold the children of pos; the left one always exists.
                if (key_reg < pick_val)
                begin
                    mem_we   = 1'b1;
                    mem_wa   = pos_reg;
                    mem_wd   = pick_val;
                    pos_next = pick_idx;
                    ra0      = nx_left[ADDR_W-1:0];
                    ra1      = nx_right[ADDR_W-1:0];
                    if (nx_left >= cnt_ext)
                    begin
                        state_next = S_PLACE;
                    end
                end
                else
                begin
                    mem_we     = 1'b1;
                    state_next = S_RESULT;
                end
            end

            S_PLACE:
            begin
                mem_we     = 1'b1;
                state_next = S_RESULT;
            end

            S_RESULT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    o_value_next = hit_reg ? top_reg : '0;
                    o_hit_next   = hit_reg;
                    o_err_next   = err_reg;
                    o_count_next = count_reg;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        key_reg     <= key_next;
        top_reg     <= top_next;
        err_reg     <= err_next;
        hit_reg     <= hit_next;
        o_value_reg <= o_value_next;
        o_hit_reg   <= o_hit_next;
        o_err_reg   <= o_err_next;
        o_count_reg <= o_count_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - KEY_W - COUNT_W){1'b0}}, o_count_reg, o_value_reg};
    assign m_axis_tuser  = {o_err_reg, o_hit_reg};

endmodule

// ===== sim/tb_max_heap_priority_queue.sv =====
// Self-checking testbench for max_heap_priority_queue: a shadow max-heap predicts every
// result beat while random stalls on both stream sides exercise the handshakes.
// Depends on mhpq_pkg and the max_heap_priority_queue RTL only.
`timescale 1ns / 1ps

module tb_max_heap_priority_queue;

    import mhpq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_OFF_CYCLES = 400;

    // One expected result beat, unpacked into its fields.
    typedef struct {
        logic signed [KEY_W-1:0] out_value;
        logic                    out_valid;
        err_t                    error_code;
        logic [COUNT_W-1:0]      count;
    } heap_result_t;

    // Shadow heap plus the queue of results that the block still owes us.
    class heap_scoreboard;
        int           keys [CAPACITY];
        int unsigned  n_keys;
        heap_result_t owed [$];
        int           failures;

        function new();
            n_keys   = 0;
            failures = 0;
        endfunction

        // Only the first ten problems are printed; the rest are just counted.
        function void report(string msg);
            failures++;
            if (failures <= 10)
            begin
                $display("ERROR at %0t: %s", $realtime, msg);
            end
        endfunction

        // Applies one accepted operation to the shadow heap and queues its result.
        function void note_input(logic func, int key);
            heap_result_t r;
            int unsigned  pos;
            int unsigned  parent;
            int unsigned  left;
            int unsigned  right;
            int unsigned  pick;
            int           tmp;
            r.out_value  = '0;
            r.out_valid  = 1'b0;
            r.error_code = ERR_NONE;
            if (func == FUNC_INSERT)
            begin
                if (n_keys >= CAPACITY)
                begin
                    r.error_code = ERR_FULL;
                end
                else
                begin
                    // Append at the end and bubble up past every smaller parent.
                    pos = n_keys;
                    keys[pos] = key;
                    n_keys++;
                    while (pos > 0)
                    begin
                        parent = (pos - 1) / 2;
                        if (keys[pos] <= keys[parent])
                        begin
                            break;
                        end
                        tmp          = keys[pos];
                        keys[pos]    = keys[parent];
                        keys[parent] = tmp;
                        pos          = parent;
                    end
                end
            end
            else if (n_keys == 0)
            begin
                r.error_code = ERR_EMPTY;
            end
            else
            begin
                r.out_value = keys[0];
                r.out_valid = 1'b1;
                n_keys--;
                keys[0] = keys[n_keys];
                // Sink the new root; on equal children the right one wins.
                pos = 0;
                forever
                begin
                    left  = 2 * pos + 1;
                    right = left + 1;
                    if (left >= n_keys)
                    begin
                        break;
                    end
                    pick = left;
                    if (right < n_keys && !(keys[left] > keys[right]))
                    begin
                        pick = right;
                    end
                    if (keys[pos] >= keys[pick])
                    begin
                        break;
                    end
                    tmp        = keys[pos];
                    keys[pos]  = keys[pick];
                    keys[pick] = tmp;
                    pos        = pick;
                end
            end
            r.count = COUNT_W'(n_keys);
            owed.push_back(r);
        endfunction

        // Compares one result beat against the oldest owed result, field by field.
        function void check_result(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
            heap_result_t want;
            if (owed.size() == 0)
            begin
                report($sformatf("unexpected result beat: tdata %h tuser %b", data, user));
                return;
            end
            want = owed.pop_front();
            if (data[31:0] !== want.out_value)
            begin
                report($sformatf("out_value: expected %0d, got %0d",
                                 want.out_value, $signed(data[31:0])));
            end
            if (data[42:32] !== want.count)
            begin
                report($sformatf("count: expected %0d, got %0d", want.count, data[42:32]));
            end
            if (user[0] !== want.out_valid)
            begin
                report($sformatf("out_valid: expected %b, got %b", want.out_valid, user[0]));
            end
            if (user[2:1] !== want.error_code)
            begin
                report($sformatf("error_code: expected %0d, got %0d",
                                 want.error_code, user[2:1]));
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // value[31:0]
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;   // func[0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // out_value[31:0], count[42:32], zero
    logic [OUT_USER_W-1:0] m_axis_tuser;         // out_valid[0], error_code[2:1]

    heap_scoreboard sb;
    int             tx_items  = 0;
    int             rx_beats  = 0;
    int             cycles    = 0;
    bit             held_once = 1'b0;

    max_heap_priority_queue uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Global watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("max_heap_priority_queue verification failed");
            $finish;
        end
    end

    // Keys are biased toward the extremes and toward a narrow range, so that
    // duplicates and equal siblings turn up often.
    function automatic int random_key();
        unique case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return int'($urandom_range(0, 7));
            4:       return -int'($urandom_range(1, 8));
            default: return int'($urandom);
        endcase
    endfunction

    // Offers one operation and returns right after the edge that accepted it.
    // Every fourth stretch of 128 beats is sent back to back with no gaps.
    task automatic send_op(input logic func, input int key);
        int gap;
        gap = (((tx_items / 128) % 4) == 2) ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        s_axis_tuser  <= func;
        do @(posedge clk); while (s_axis_tready !== 1'b1);
        sb.note_input(func, key);
        tx_items++;
    endtask

    task automatic send_random_mix(input int n_ops, input int insert_pct);
        repeat (n_ops)
        begin
            send_op(($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_EXTRACT,
                    random_key());
        end
    endtask

    // Result side. It stalls a random number of cycles before each beat, runs
    // without stalls in every fourth stretch of 100 beats, and once holds off for
    // a long stretch so that the block backs up and drops s_axis_tready.
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_beats == 150 && !held_once)
            begin
                held_once = 1'b1;
                gap = HOLD_OFF_CYCLES;
            end
            else
            begin
                gap = (((rx_beats / 100) % 4) == 1) ? 0 : $urandom_range(0, 4);
            end
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (m_axis_tvalid !== 1'b1);
            sb.check_result(m_axis_tdata, m_axis_tuser);
            rx_beats++;
        end
    end

    initial
    begin
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty extract, extreme and repeated keys, then a full drain.
        send_op(FUNC_EXTRACT, 32'h1234_5678);
        send_op(FUNC_INSERT, 32'h7FFF_FFFF);
        send_op(FUNC_INSERT, 32'h8000_0000);
        send_op(FUNC_INSERT, 0);
        send_op(FUNC_INSERT, -1);
        send_op(FUNC_INSERT, 1);
        send_op(FUNC_INSERT, 5);
        send_op(FUNC_INSERT, 5);
        send_op(FUNC_INSERT, 5);
        send_op(FUNC_INSERT, 32'h7FFF_FFFF);
        repeat (4) send_op(FUNC_EXTRACT, int'($urandom));
        send_op(FUNC_INSERT, 32'h8000_0000);
        send_op(FUNC_INSERT, 32'h8000_0000);
        while (sb.n_keys > 0)
        begin
            send_op(FUNC_EXTRACT, int'($urandom));
        end
        send_op(FUNC_EXTRACT, 32'hFFFF_FFFF);

        // Random part: a balanced mix near the bottom of the heap, a fill to
        // capacity with overflow attempts, then an extract-heavy stretch from full
        // depth so that the sift-down walks every level.
        send_random_mix(130, 55);
        while (sb.n_keys < CAPACITY)
        begin
            send_op(FUNC_INSERT, random_key());
        end
        repeat (6) send_op(FUNC_INSERT, random_key());
        send_random_mix(130, 25);

        s_axis_tvalid <= 1'b0;
        while (sb.owed.size() > 0)
        begin
            @(posedge clk);
        end
        // Keep running after the last owed result so that any stray extra beat is caught.
        repeat (30) @(posedge clk);

        if (sb.failures == 0)
        begin
            $display("max_heap_priority_queue verification clean");
        end
        else
        begin
            $display("max_heap_priority_queue verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mhpq_pkg.sv
rtl/max_heap_priority_queue.sv
sim/tb_max_heap_priority_queue.sv
